// ===== rtl/qse_pkg.sv =====
// Package for the quoted string escaper.
// Holds the quote style codes, the character constants and the escape lookup functions.
// No dependencies.
package qse_pkg;

  typedef enum logic [1:0] {
    StyleYamlDq = 2'd0,
    StyleYamlSq = 2'd1,
    StyleJson   = 2'd2
  } quote_style_e;

  localparam int unsigned MaxRun    = 8;  // longest output run for one input word
  localparam int unsigned MaxEscape = 6;  // longest escape sequence (\u00HH)

  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChApos      = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChDel       = 8'h7f;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChLowerX    = 8'h78;

  // Lower case ASCII hex digit.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h57 + {4'h0, nib};
    end
    return r;
  endfunction

  // Named escape letter in YAML double-quoted style, zero when there is none.
  function automatic logic [7:0] yaml_named(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h00:   r = 8'h30;  // 0
      8'h07:   r = 8'h61;  // a
      8'h08:   r = 8'h62;  // b
      8'h09:   r = 8'h74;  // t
      8'h0a:   r = 8'h6e;  // n
      8'h0b:   r = 8'h76;  // v
      8'h0c:   r = 8'h66;  // f
      8'h0d:   r = 8'h72;  // r
      8'h1b:   r = 8'h65;  // e
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Named escape letter in JSON style, zero when there is none.
  function automatic logic [7:0] json_named(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h08:   r = 8'h62;
      8'h09:   r = 8'h74;
      8'h0a:   r = 8'h6e;
      8'h0c:   r = 8'h66;
      8'h0d:   r = 8'h72;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/qse_in_if.sv =====
// Input channel of the quoted string escaper: one raw string byte and its marks per word.
// Valid/ready handshake; no dependencies.
interface qse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       first_of_string;
  logic       last_of_string;
  logic       empty_string;

  modport source (output valid, char_byte, first_of_string, last_of_string, empty_string,
                  input ready);
  modport sink (input valid, char_byte, first_of_string, last_of_string, empty_string,
                output ready);
endinterface

// ===== rtl/qse_out_if.sv =====
// Output channel of the quoted string escaper: one byte of quoted text per word.
// Valid/ready handshake; no dependencies.
interface qse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== rtl/quoted_string_escaper.sv =====
// Quoted string escaper top level: input register, escape expansion, output run register.
// An accepted input word is held in the input register, then loaded into the run register once that is free.
// Throughput: one output byte per cycle while the output is ready; an input word that expands to n bytes
// holds the run register until its last byte is taken, so plain bytes flow one word per cycle.
// Reset clears the valid flags of both stages and sets the quote style to YAML double-quoted.
// Depends on qse_pkg, qse_in_if and qse_out_if.
module quoted_string_escaper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  qse_in_if.sink              in_i,
  qse_out_if.source           out_o
);
  import qse_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxRun);
  localparam int unsigned EscW = $clog2(MaxEscape + 1);

  logic [1:0]       style_q;

  // input stage
  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             first_q;
  logic             last_q;
  logic             empty_q;

  // run stage
  logic             run_valid_q;
  logic [7:0]       run_bytes_q [MaxRun];
  logic [IdxW-1:0]  run_end_q;
  logic [IdxW-1:0]  idx_q;

  logic             run_done;
  logic             load;

  logic [7:0]       quote;
  logic [7:0]       esc [MaxEscape];
  logic [EscW-1:0]  esc_len;
  logic [7:0]       slot_d [MaxRun];
  logic [IdxW:0]    run_len;
  logic [IdxW-1:0]  run_end_d;
  logic [7:0]       named;

  assign run_done    = out_o.valid && out_o.ready && out_o.last_of_run;
  assign load        = in_valid_q && (!run_valid_q || run_done);
  assign in_i.ready  = !in_valid_q || load;

  assign out_o.valid       = run_valid_q;
  assign out_o.out_byte    = run_bytes_q[idx_q];
  assign out_o.last_of_run = (idx_q == run_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q <= StyleYamlDq;
    end else if (cfg_we_i) begin
      style_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q  <= in_i.char_byte;
      first_q <= in_i.first_of_string;
      last_q  <= in_i.last_of_string;
      empty_q <= in_i.empty_string;
    end
  end

  // Escape sequence for the held byte.
  always_comb begin
    named = 8'h00;
    for (int j = 0; j < MaxEscape; j++) begin
      esc[j] = char_q;
    end
    esc_len = EscW'(1);
    case (style_q)
      StyleYamlSq: begin
        if (char_q == ChApos) begin
          esc[1]  = ChApos;
          esc_len = EscW'(2);
        end
      end
      StyleJson: begin
        named = json_named(char_q);
        if (char_q == ChDquote || char_q == ChBackslash) begin
          esc[0]  = ChBackslash;
          esc[1]  = char_q;
          esc_len = EscW'(2);
        end else if (named != 8'h00) begin
          esc[0]  = ChBackslash;
          esc[1]  = named;
          esc_len = EscW'(2);
        end else if (char_q < ChSpace) begin
          esc[0]  = ChBackslash;
          esc[1]  = ChLowerU;
          esc[2]  = ChZero;
          esc[3]  = ChZero;
          esc[4]  = hex_digit(char_q[7:4]);
          esc[5]  = hex_digit(char_q[3:0]);
          esc_len = EscW'(6);
        end
      end
      default: begin
        named = yaml_named(char_q);
        if (char_q == ChDquote || char_q == ChBackslash) begin
          esc[0]  = ChBackslash;
          esc[1]  = char_q;
          esc_len = EscW'(2);
        end else if (char_q < ChSpace || char_q == ChDel) begin
          esc[0] = ChBackslash;
          if (named != 8'h00) begin
            esc[1]  = named;
            esc_len = EscW'(2);
          end else begin
            esc[1]  = ChLowerX;
            esc[2]  = hex_digit(char_q[7:4]);
            esc[3]  = hex_digit(char_q[3:0]);
            esc_len = EscW'(4);
          end
        end
      end
    endcase
  end

  // Place the escape behind an optional opening quote; every other slot holds the quote.
  always_comb begin
    quote = (style_q == StyleYamlSq) ? ChApos : ChDquote;
    for (int k = 0; k < MaxRun; k++) begin
      slot_d[k] = quote;
    end
    if (empty_q) begin
      run_len = (IdxW + 1)'(2);
    end else begin
      for (int j = 0; j < MaxEscape; j++) begin
        if (EscW'(j) < esc_len) begin
          slot_d[IdxW'(j) + IdxW'(first_q)] = esc[j];
        end
      end
      run_len = (IdxW + 1)'(esc_len) + (IdxW + 1)'(first_q) + (IdxW + 1)'(last_q);
    end
    run_end_d = IdxW'(run_len - (IdxW + 1)'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      run_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (run_done) begin
      run_valid_q <= 1'b0;
    end else if (out_o.valid && out_o.ready) begin
      idx_q <= idx_q + IdxW'(1);  // advance within the run
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_bytes_q <= slot_d;
      run_end_q   <= run_end_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> idx_q <= run_end_q)
    else $error("run index past end of run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last_of_run) |=> out_o.valid)
    else $error("run dropped before its last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_done && !load) |=> !run_valid_q)
    else $error("run stage stays valid after last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !load) |=> in_valid_q)
    else $error("held input word lost");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for quoted_string_escaper: string words in, quoted text words out.
// Predicts the escaped text per accepted word and checks every output word in order.
// Depends on qse_pkg, qse_in_if, qse_out_if and the quoted_string_escaper top level.
module testbench;
  import qse_pkg::*;

  localparam logic [1:0]  StyleUnused  = 2'd3;  // spare code, acts as YAML double-quoted
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned CycleLimit   = 150000;
  localparam int unsigned MaxPrinted   = 200;
  localparam logic [7:0]  TrickyBytes [19] = '{
    8'h22, 8'h27, 8'h5c, 8'h00, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c,
    8'h0d, 8'h1b, 8'h01, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'hff
  };

  typedef struct packed {
    logic [7:0] char_byte;
    logic       first_of_string;
    logic       last_of_string;
    logic       empty_string;
  } str_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } text_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic       hold_start;

  qse_in_if  str_in ();
  qse_out_if lit_out ();

  str_word_t   pending_words_q [$];
  text_word_t  expected_text_q [$];
  logic [1:0]  cur_style;
  int unsigned words_queued   = 0;
  int unsigned words_accepted = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;

  quoted_string_escaper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (str_in),
    .out_o       (lit_out)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    // keep the log short when the block is badly off
    if (mismatch_count < MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // Expand one string word into the quoted text it should produce.
  function automatic void predict_escape(input str_word_t w);
    quote_style_e style;
    logic [7:0]   quote;
    logic [7:0]   c;
    logic [7:0]   named;
    logic [7:0]   run [$];
    string        hex_chars;
    text_word_t   t;
    hex_chars = "0123456789abcdef";
    style = (cur_style == StyleUnused) ? StyleYamlDq : quote_style_e'(cur_style);
    quote = (style == StyleYamlSq) ? ChApos : ChDquote;
    c = w.char_byte;
    if (w.empty_string) begin
      run.push_back(quote);
      run.push_back(quote);
    end else begin
      if (w.first_of_string) run.push_back(quote);
      if (style == StyleYamlSq) begin
        run.push_back(c);
        if (c == ChApos) run.push_back(c);
      end else if (c == ChDquote || c == ChBackslash) begin
        run.push_back(ChBackslash);
        run.push_back(c);
      end else if (style == StyleJson) begin
        case (c)
          8'h08:   named = "b";
          8'h09:   named = "t";
          8'h0a:   named = "n";
          8'h0c:   named = "f";
          8'h0d:   named = "r";
          default: named = 8'h00;
        endcase
        if (named != 8'h00) begin
          run.push_back(ChBackslash);
          run.push_back(named);
        end else if (c < ChSpace) begin
          run.push_back(ChBackslash);
          run.push_back(ChLowerU);
          run.push_back(ChZero);
          run.push_back(ChZero);
          run.push_back(hex_chars[c[7:4]]);
          run.push_back(hex_chars[c[3:0]]);
        end else begin
          run.push_back(c);
        end
      end else if (c < ChSpace || c == ChDel) begin
        case (c)
          8'h00:   named = "0";
          8'h07:   named = "a";
          8'h08:   named = "b";
          8'h09:   named = "t";
          8'h0a:   named = "n";
          8'h0b:   named = "v";
          8'h0c:   named = "f";
          8'h0d:   named = "r";
          8'h1b:   named = "e";
          default: named = 8'h00;
        endcase
        run.push_back(ChBackslash);
        if (named != 8'h00) begin
          run.push_back(named);
        end else begin
          run.push_back(ChLowerX);
          run.push_back(hex_chars[c[7:4]]);
          run.push_back(hex_chars[c[3:0]]);
        end
      end else begin
        run.push_back(c);
      end
      if (w.last_of_string) run.push_back(quote);
    end
    foreach (run[k]) begin
      t.out_byte    = run[k];
      t.last_of_run = (k == run.size() - 1);
      expected_text_q.push_back(t);
    end
  endfunction

  // A mix of control bytes, quote characters, backslash or DEL, printable bytes and any byte at all.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2: c = 8'($urandom_range(31));
      3: begin
        case ($urandom_range(3))
          0:       c = ChDquote;
          1:       c = ChApos;
          2:       c = ChBackslash;
          default: c = ChDel;
        endcase
      end
      4, 5:    c = 8'($urandom_range(255));
      default: c = 8'($urandom_range(126, 32));
    endcase
    return c;
  endfunction

  task automatic push_word(input logic [7:0] c, input logic first, last, empty);
    str_word_t w;
    w.char_byte       = c;
    w.first_of_string = first;
    w.last_of_string  = last;
    w.empty_string    = empty;
    pending_words_q.push_back(w);
    words_queued++;
  endtask

  // Whole strings with random content, plus some words with random marks.
  task automatic queue_random_text(input int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) begin
        push_word(8'($urandom_range(255)), 1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = $urandom_range(6);
        if (len == 0) begin
          push_word(pick_char(), 1'($urandom), 1'($urandom), 1'b1);
          sent++;
        end else begin
          for (int unsigned k = 0; k < len; k++) begin
            push_word(pick_char(), k == 0, k == len - 1, 1'b0);
            sent++;
          end
        end
      end
    end
  endtask

  // Hold until every queued word is taken and all its text has come out, or DrainLimit runs out.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    while ((words_accepted != words_queued || expected_text_q.size() != 0) &&
           waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_style(input logic [1:0] style);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= style;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_style = style;
  endtask

  task automatic run_phase(input logic [1:0] style, input int unsigned send_pct, recv_pct,
                           n_words, input bit squeeze);
    wait_drained();
    write_style(style);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      @(posedge clk_i);
      hold_start <= 1'b1;
      @(posedge clk_i);
      hold_start <= 1'b0;
    end
    queue_random_text(n_words);
  endtask

  // Sender: present the next pending word, hold it until taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    str_word_t nxt;
    if (!rst_ni) begin
      str_in.valid           <= 1'b0;
      str_in.char_byte       <= 8'h00;
      str_in.first_of_string <= 1'b0;
      str_in.last_of_string  <= 1'b0;
      str_in.empty_string    <= 1'b0;
    end else begin
      if (str_in.valid && str_in.ready) begin
        predict_escape({str_in.char_byte, str_in.first_of_string, str_in.last_of_string,
                        str_in.empty_string});
        words_accepted++;
      end
      if (!str_in.valid || str_in.ready) begin
        if (pending_words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_words_q.pop_front();
          str_in.valid           <= 1'b1;
          str_in.char_byte       <= nxt.char_byte;
          str_in.first_of_string <= nxt.first_of_string;
          str_in.last_of_string  <= nxt.last_of_string;
          str_in.empty_string    <= nxt.empty_string;
        end else begin
          str_in.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: compare each text word with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : check_text
    text_word_t want;
    if (!rst_ni) begin
      lit_out.ready <= 1'b0;
    end else begin
      if (lit_out.valid && lit_out.ready) begin
        if (expected_text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word out_byte=%h last_of_run=%b",
                                    lit_out.out_byte, lit_out.last_of_run));
        end else begin
          want = expected_text_q.pop_front();
          if (lit_out.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte got %h want %h",
                                      lit_out.out_byte, want.out_byte));
          end
          if (lit_out.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run got %b want %b (out_byte %h)",
                                      lit_out.last_of_run, want.last_of_run, want.out_byte));
          end
        end
      end
      lit_out.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = StyleYamlDq;
    cur_style   = StyleYamlDq;
    hold_start  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset style: one-byte string, empty strings with junk in the ignored fields,
    // then a string of every awkward byte, then stray marks.
    push_word("A", 1'b1, 1'b1, 1'b0);
    push_word(8'hff, 1'b0, 1'b0, 1'b1);
    push_word(ChDquote, 1'b1, 1'b1, 1'b1);
    foreach (TrickyBytes[k]) begin
      push_word(TrickyBytes[k], k == 0, k == $size(TrickyBytes) - 1, 1'b0);
    end
    push_word("z", 1'b0, 1'b1, 1'b0);
    push_word("q", 1'b1, 1'b0, 1'b0);

    run_phase(StyleYamlSq, 0, 0, 70, 1'b0);
    run_phase(StyleJson, 56, 0, 60, 1'b0);
    run_phase(StyleUnused, 0, 56, 50, 1'b0);
    run_phase(StyleYamlDq, 34, 34, 60, 1'b0);
    // receiver stalls long while words keep coming, so the block backs up
    run_phase(StyleJson, 0, 0, 40, 1'b1);
    run_phase(StyleYamlSq, 34, 34, 40, 1'b0);
    wait_drained();

    if (expected_text_q.size() != 0) begin
      report_mismatch($sformatf("%0d text words never came out", expected_text_q.size()));
    end
    if (words_accepted != words_queued) begin
      report_mismatch($sformatf("only %0d of %0d string words taken",
                                words_accepted, words_queued));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
